// ----- design/token_bucket_shaper_defines.svh -----
// Assertion macros for the token bucket shaper.
`ifndef TOKEN_BUCKET_SHAPER_DEFINES_SVH
`define TOKEN_BUCKET_SHAPER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tbs_pkg.sv -----
`default_nettype none

package tbs_pkg;

  // Field widths fixed by the packet and register formats
  localparam int TOKEN_W   = 32;
  localparam int RATE_W    = 32;
  localparam int LEN_W     = 16;
  localparam int ID_W      = 32;
  localparam int CFG_IDX_W = 1;

  // Defaults for the top-level parameters
  localparam int TIME_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_RATE  = 1'd1;

  // Register reset values
  localparam logic [TOKEN_W-1:0] BUCKET_RESET = 32'd1024;
  localparam logic [RATE_W-1:0]  RATE_RESET   = 32'd65536;

endpackage

`default_nettype wire

// ----- design/tbs_mul.sv -----
`default_nettype none

// Shift-and-add multiplier: one rate bit per cycle, LSB first.
module tbs_mul import tbs_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [TIME_BITS-1:0]           elapsed,
  input  wire logic [RATE_W-1:0]              rate,
  output logic                                done,
  output logic [TIME_BITS+RATE_W-1:0]         product
);

  localparam int PW    = TIME_BITS + RATE_W;
  localparam int CNT_W = $clog2(RATE_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [TIME_BITS-1:0] mcand;
  logic [PW-1:0]        prod;
  logic [TIME_BITS:0]   sum;

  // Multiplier bits sit in the low end of prod and shift out as the sum shifts in
  assign sum = {1'b0, prod[PW-1:RATE_W]} + (prod[0] ? {1'b0, mcand} : '0);
  assign product = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(RATE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= elapsed;
      prod  <= {{TIME_BITS{1'b0}}, rate};
    end else if (busy) begin
      prod <= {sum, prod[RATE_W-1:1]};
    end
  end

endmodule

`default_nettype wire

// ----- design/tbs_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle, then round up and saturate.
module tbs_div import tbs_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [LEN_W-1:0]     deficit,
  input  wire logic [RATE_W-1:0]    rate,
  output logic                      done,
  output logic [TIME_BITS-1:0]      wait_time
);

  localparam int SH    = 2 * FRAC_BITS;
  localparam int QW    = LEN_W + SH;
  localparam int CNT_W = $clog2(QW);
  localparam int XW    = (QW + 1 > TIME_BITS) ? QW + 1 : TIME_BITS;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic             busy;
  logic             rnd;
  logic [CNT_W-1:0] cnt;
  logic [QW-1:0]    quo;
  logic [RATE_W-1:0] rem;
  logic [RATE_W:0]  shifted;
  logic [RATE_W:0]  diff;
  logic             ge;
  logic [XW-1:0]    q_up;
  logic [XW-1:0]    t_max;

  assign shifted = {rem, quo[QW-1]};
  assign diff    = shifted - {1'b0, rate};
  assign ge      = shifted >= {1'b0, rate};
  // Round up on any remainder, compare against the time ceiling
  assign q_up    = XW'(quo) + XW'(rem != '0);
  assign t_max   = XW'(TIME_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      rnd  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QW - 1)) begin
          busy <= 1'b0;
          rnd  <= 1'b1;
        end
      end else if (rnd) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= QW'(deficit) << SH;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
      quo <= {quo[QW-2:0], ge};
    end
    if (rnd) begin
      wait_time <= (q_up > t_max) ? TIME_MAX : q_up[TIME_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/token_bucket_shaper.sv -----
// Channel  Direction  Handshake               Words carried
// pkt      in         pkt_valid / pkt_stall   arrival_time, packet_id, packet_length
// dep      out        dep_valid / dep_stall   departure_time, departed_id, departed_length
// cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One packet is in work at a time; the next is taken once the result sits in the
// output register. When the arrival is later than the last time, a bit-serial token
// gain multiply runs, one rate bit a cycle; when the bucket is short and the rate is
// not zero, a bit-serial wait division runs.
// Reset (rst, synchronous) clears control, loads the registers with their defaults
// and fills the bucket. A stalled result holds in the output register; the packet
// behind it finishes and holds in the done state.
`default_nettype none
`include "token_bucket_shaper_defines.svh"

module token_bucket_shaper import tbs_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // packet words
  input  wire logic                  pkt_valid,
  output logic                       pkt_stall,
  input  wire logic [TIME_BITS-1:0]  arrival_time,
  input  wire logic [ID_W-1:0]       packet_id,
  input  wire logic [LEN_W-1:0]      packet_length,
  // departure words
  output logic                       dep_valid,
  input  wire logic                  dep_stall,
  output logic [TIME_BITS-1:0]       departure_time,
  output logic [ID_W-1:0]            departed_id,
  output logic [LEN_W-1:0]           departed_length,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [TOKEN_W-1:0]    cfg_data
);

  localparam int PW = TIME_BITS + RATE_W;
  localparam int SH = 2 * FRAC_BITS;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GAP   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_GAIN  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_ADD   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]           state;
  logic [TOKEN_W-1:0]   bucket_size;
  logic [RATE_W-1:0]    token_rate;
  logic [TIME_BITS-1:0] last_time;
  logic [TOKEN_W-1:0]   token_count;
  logic [TOKEN_W-1:0]   room;
  logic [TIME_BITS-1:0] arr;
  logic [ID_W-1:0]      pid;
  logic [LEN_W-1:0]     plen;

  logic [TIME_BITS:0]   gap;
  logic                 later;
  logic                 mul_start;
  logic                 mul_done;
  logic [PW-1:0]        product;
  logic [PW-1:0]        gain;
  logic                 fits;
  logic [LEN_W-1:0]     deficit;
  logic                 div_start;
  logic                 div_done;
  logic [TIME_BITS-1:0] wait_time;
  logic [TIME_BITS:0]   late_sum;
  logic                 out_free;

  assign pkt_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Elapsed time; the borrow bit tells an early arrival, a zero gap an equal one
  assign gap       = {1'b0, arr} - {1'b0, last_time};
  assign later     = !gap[TIME_BITS] && (gap != '0);
  assign mul_start = (state == S_GAP) && later;

  // Whole tokens only: drop the fraction bits of the 32.16 x 16.16 product
  assign gain      = product >> SH;

  assign fits      = (TOKEN_W'(plen) <= token_count);
  // Only used when the bucket is short, so the count fits the length width
  assign deficit   = plen - token_count[LEN_W-1:0];
  assign div_start = (state == S_CHECK) && !fits && (token_rate != '0);

  assign late_sum  = {1'b0, last_time} + {1'b0, wait_time};
  assign out_free  = !dep_valid || !dep_stall;

  tbs_mul #(
    .TIME_BITS (TIME_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .elapsed (gap[TIME_BITS-1:0]),
    .rate    (token_rate),
    .done    (mul_done),
    .product (product)
  );

  tbs_div #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .deficit   (deficit),
    .rate      (token_rate),
    .done      (div_done),
    .wait_time (wait_time)
  );

  // Sequencer and shaper state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      dep_valid   <= 1'b0;
      bucket_size <= BUCKET_RESET;
      token_rate  <= RATE_RESET;
      token_count <= BUCKET_RESET;
      last_time   <= '0;
    end else begin
      // drop the result once taken; a new load below overrides
      if (dep_valid && !dep_stall) begin
        dep_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (pkt_valid) begin
            state <= S_GAP;
          end
        end
        S_GAP: begin
          // hold the free room for the cap while the multiply runs
          room  <= (bucket_size > token_count) ? bucket_size - token_count : '0;
          state <= later ? S_MUL : S_CHECK;
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          // cap at the bucket size and move the clock to the arrival
          if (gain >= {{(PW-TOKEN_W){1'b0}}, room}) begin
            token_count <= bucket_size;
          end else begin
            token_count <= token_count + gain[TOKEN_W-1:0];
          end
          last_time <= arr;
          state     <= S_CHECK;
        end
        S_CHECK: begin
          if (fits) begin
            token_count <= token_count - TOKEN_W'(plen);
            state       <= S_DONE;
          end else begin
            // empty the bucket; a zero rate never refills it
            token_count <= '0;
            if (token_rate == '0) begin
              last_time <= TIME_MAX;
              state     <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          // saturate the advanced time at its maximum
          last_time <= late_sum[TIME_BITS] ? TIME_MAX : late_sum[TIME_BITS-1:0];
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            dep_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Register writes must arrive only while idle; the block itself does not enforce it
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BUCKET_SIZE: begin
            bucket_size <= cfg_data;
            token_count <= cfg_data;
          end
          CFG_TOKEN_RATE: begin
            token_rate <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Packet capture and result register
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && pkt_valid) begin
      arr  <= arrival_time;
      pid  <= packet_id;
      plen <= packet_length;
    end
    if ((state == S_DONE) && out_free) begin
      departure_time  <= last_time;
      departed_id     <= pid;
      departed_length <= plen;
    end
  end

  // Checks on the sequencer and the bucket
  `TBS_ASSERT_NOW(a_bucket_cap, 1'b1, token_count <= bucket_size,
    "token count above bucket size")
  `TBS_ASSERT_NOW(a_mul_done_state, mul_done, state == S_MUL,
    "multiplier finished outside its wait state")
  `TBS_ASSERT_NOW(a_div_done_state, div_done, state == S_DIV,
    "divider finished outside its wait state")
  `TBS_ASSERT_NEXT(a_load_from_done, (state == S_DONE) && out_free,
    dep_valid && (state == S_IDLE), "result not loaded on completion")

endmodule

`default_nettype wire
